/* rtl/bfra_pkg.sv */
package bfra_pkg;

    localparam int MaxRegions   = 64;
    localparam int PoolAddrBits = 24;
    localparam int IdxW         = $clog2(MaxRegions);
    localparam int CntW         = $clog2(MaxRegions + 1);
    localparam int LenW         = PoolAddrBits + 1;
    localparam int GrowW        = 11;
    localparam int EntW         = PoolAddrBits + LenW + 1;
    localparam logic [LenW-1:0] PoolLimit = LenW'(1) << PoolAddrBits;
    localparam logic [LenW-1:0] CapReset  = LenW'(4096);
    localparam logic [GrowW-1:0] GrowReset = GrowW'(512);
    localparam logic [GrowW-1:0] GrowMin   = GrowW'(257);

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StZero     = 3'd1;
    localparam logic [2:0] StFull     = 3'd2;
    localparam logic [2:0] StOverflow = 3'd3;
    localparam logic [2:0] StBadFree  = 3'd4;

    localparam logic CmdAlloc = 1'b0;
    localparam logic CmdFree  = 1'b1;

    localparam logic CfgCapacity = 1'b0;
    localparam logic CfgGrowth   = 1'b1;

    typedef struct packed {
        logic [PoolAddrBits-1:0] start;
        logic [LenW-1:0]         len;
        logic                    free;
    } entry_t;

    typedef struct packed {
        logic            we;
        logic [IdxW-1:0] waddr;
        entry_t          wdata;
        logic [IdxW-1:0] raddr;
    } mem_req_t;

endpackage

/* rtl/best_fit_region_allocator_top.sv */
// Operation: a zero size is answered without a scan; an allocation scans every region,
// a split then shifts the entries above the fit up, and growth repeats growth steps until
// the space at the end of the pool fits the request; a free scans up to its region, and a
// merge shifts the entries above it down. A growth factor near 1.0 can need a few thousand growth steps.
// Throughput: one request at a time; a waiting result holds off the next request.
// Reset (aresetn low, synchronous): one free region of 4096 bytes, growth 2.0; entry 0 is written in S_INIT.
import bfra_pkg::*;
module best_fit_region_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // req_size[24:0], req_address[48:25]
    input  logic        s_tuser,  // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // status[2:0], alloc_address[26:3], resized[27]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data
);

    mem_req_t        mreq;
    entry_t          rdata;
    logic [EntW-1:0] rraw;
    logic            g_start, g_done;
    logic [LenW-1:0] g_cap, g_result;
    logic [GrowW-1:0] g_growth;
    logic [2:0]      st;
    logic [PoolAddrBits-1:0] adr;
    logic            rsz;

    assign rdata = entry_t'(rraw);

    bfra_ram #(.Width(EntW), .Depth(MaxRegions)) u_ram (
        .aclk(aclk), .we(mreq.we), .waddr(mreq.waddr), .wdata(mreq.wdata),
        .raddr(mreq.raddr), .rdata(rraw));

    bfra_grow u_grow (
        .aclk(aclk), .aresetn(aresetn), .start(g_start), .cap_in(g_cap),
        .growth(g_growth), .done(g_done), .cap_out(g_result));

    bfra_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .cmd(s_tuser), .req_size(s_tdata[24:0]), .req_address(s_tdata[48:25]),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_cap(cfg_data), .cfg_grow(cfg_data[GrowW-1:0]),
        .mreq(mreq), .rdata(rdata), .g_start(g_start), .g_cap(g_cap),
        .g_growth(g_growth), .g_done(g_done), .g_result(g_result),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .o_status(st), .o_addr(adr),
        .o_resized(rsz));

    assign m_tdata = {4'b0, rsz, adr, st};

endmodule

/* rtl/bfra_ram.sv */
module bfra_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bfra_grow.sv */
import bfra_pkg::*;
module bfra_grow (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [LenW-1:0]  cap_in,
    input  logic [GrowW-1:0] growth,
    output logic             done,
    output logic [LenW-1:0]  cap_out
);

    logic [LenW+GrowW-1:0] prod_reg, prod_next;
    logic                  busy_reg;
    logic [LenW-1:0]       cap_reg;
    logic [GrowW-1:0]      g;
    logic [LenW+GrowW-1:0] shifted;

    assign g       = (growth < GrowMin) ? GrowMin : growth;
    assign prod_next = (LenW+GrowW)'(cap_in) * (LenW+GrowW)'(g);
    assign shifted = prod_reg >> 8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= start;
        end
        prod_reg <= prod_next;
        cap_reg  <= cap_in;
    end

    assign done = busy_reg;
    always_comb begin
        if (shifted > (LenW+GrowW)'(PoolLimit)) begin
            cap_out = PoolLimit + LenW'(1);
        end else if (shifted[LenW-1:0] <= cap_reg) begin
            cap_out = cap_reg + LenW'(1);
        end else begin
            cap_out = shifted[LenW-1:0];
        end
    end

endmodule

/* rtl/bfra_ctrl.sv */
import bfra_pkg::*;
module bfra_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    cmd,
    input  logic [LenW-1:0]         req_size,
    input  logic [PoolAddrBits-1:0] req_address,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic [LenW-1:0]         cfg_cap,
    input  logic [GrowW-1:0]        cfg_grow,
    output mem_req_t                mreq,
    input  entry_t                  rdata,
    output logic                    g_start,
    output logic [LenW-1:0]         g_cap,
    output logic [GrowW-1:0]        g_growth,
    input  logic                    g_done,
    input  logic [LenW-1:0]         g_result,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [2:0]              o_status,
    output logic [PoolAddrBits-1:0] o_addr,
    output logic                    o_resized
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SCAN  = 12'b000000000010,
        S_DEC   = 12'b000000000100,
        S_GROW  = 12'b000000001000,
        S_GWAIT = 12'b000000010000,
        S_SHUP  = 12'b000000100000,
        S_SHDN  = 12'b000001000000,
        S_FIX   = 12'b000010000000,
        S_RD    = 12'b000100000000,
        S_FREE  = 12'b001000000000,
        S_INIT  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t                  st_reg, st_next;
    logic [CntW-1:0]         cnt_reg, cnt_next;
    logic [LenW-1:0]         cap_reg, cap_next;
    logic [GrowW-1:0]        grow_reg, grow_next;
    logic [LenW-1:0]         icap_reg, icap_next;
    logic [LenW-1:0]         size_reg, size_next;
    logic [PoolAddrBits-1:0] fadr_reg, fadr_next;
    logic [CntW-1:0]         i_reg, i_next;
    logic                    found_reg, found_next;
    logic [IdxW-1:0]         best_reg, best_next;
    entry_t                  bent_reg, bent_next;
    entry_t                  prev_reg, prev_next;
    entry_t                  last_reg, last_next;
    logic [LenW-1:0]         glen_reg, glen_next;
    logic [LenW-1:0]         gcap_reg, gcap_next;
    logic [CntW-1:0]         pos_reg, pos_next;
    logic [CntW-1:0]         tgt_reg, tgt_next;
    logic [1:0]              ph_reg, ph_next;
    entry_t                  w0_reg, w0_next;
    entry_t                  w1_reg, w1_next;
    logic                    two_reg, two_next;
    logic                    del_reg, del_next;
    logic [2:0]              sta_reg, sta_next;
    logic [PoolAddrBits-1:0] adr_reg, adr_next;
    logic                    rsz_reg, rsz_next;
    logic                    ov_reg, ov_next;
    logic [2:0]              cst_reg, cst_next;

    logic [CntW-1:0] scan_idx;
    logic [CntW-1:0] need;
    logic [LenW:0]   lsum;

    assign scan_idx = i_reg - CntW'(1);
    assign s_tready = (st_reg == S_IDLE) && !ov_reg && !cfg_valid;
    assign cfg_ready = (st_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign o_status = sta_reg;
    assign o_addr = adr_reg;
    assign o_resized = rsz_reg;
    assign g_cap = gcap_reg;
    assign g_growth = grow_reg;

    always_comb begin
        st_next = st_reg; cnt_next = cnt_reg; cap_next = cap_reg;
        grow_next = grow_reg; icap_next = icap_reg;
        size_next = size_reg; fadr_next = fadr_reg; i_next = i_reg;
        found_next = found_reg; best_next = best_reg; bent_next = bent_reg;
        prev_next = prev_reg; last_next = last_reg; glen_next = glen_reg;
        gcap_next = gcap_reg; pos_next = pos_reg; tgt_next = tgt_reg;
        ph_next = ph_reg; w0_next = w0_reg; w1_next = w1_reg;
        two_next = two_reg; del_next = del_reg; sta_next = sta_reg;
        adr_next = adr_reg; rsz_next = rsz_reg; ov_next = ov_reg;
        cst_next = cst_reg;
        mreq = '0;
        g_start = 1'b0;
        need = '0;
        lsum = '0;
        if (ov_reg && m_tready) begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            S_IDLE: begin
                if (cfg_valid && cfg_ready) begin
                    if (cfg_index == CfgCapacity) begin
                        icap_next = cfg_cap;
                        st_next = S_INIT;
                    end else begin
                        grow_next = cfg_grow;
                    end
                end else if (s_tvalid && s_tready) begin
                    size_next = req_size; fadr_next = req_address;
                    i_next = '0; found_next = 1'b0;
                    sta_next = StOk; adr_next = '0; rsz_next = 1'b0;
                    mreq.raddr = '0;
                    if (cmd == CmdAlloc && req_size == '0) begin
                        sta_next = StZero;
                        st_next = S_OUT;
                    end else begin
                        i_next = CntW'(1);
                        st_next = (cmd == CmdAlloc) ? S_SCAN : S_FREE;
                    end
                end
            end
            S_INIT: begin
                cap_next = (icap_reg == '0) ? LenW'(1)
                         : (icap_reg > PoolLimit) ? PoolLimit : icap_reg;
                mreq.we = 1'b1;
                mreq.wdata = '{start: '0, len: cap_next, free: 1'b1};
                cnt_next = CntW'(1);
                st_next = S_IDLE;
            end
            S_SCAN: begin
                mreq.raddr = i_reg[IdxW-1:0];
                if (rdata.free && rdata.len >= size_reg
                    && (!found_reg || rdata.len < bent_reg.len)) begin
                    found_next = 1'b1;
                    best_next = scan_idx[IdxW-1:0];
                    bent_next = rdata;
                end
                last_next = rdata;
                if (i_reg == cnt_reg) begin
                    st_next = S_DEC;
                end else begin
                    i_next = i_reg + CntW'(1);
                end
            end
            S_DEC: begin
                if (found_reg) begin
                    if (bent_reg.len != size_reg && cnt_reg == CntW'(MaxRegions)) begin
                        sta_next = StFull; st_next = S_OUT;
                    end else begin
                        adr_next = bent_reg.start;
                        w0_next = '{start: bent_reg.start, len: size_reg, free: 1'b0};
                        w1_next = '{start: bent_reg.start + size_reg[PoolAddrBits-1:0],
                                    len: bent_reg.len - size_reg, free: 1'b1};
                        two_next = bent_reg.len != size_reg;
                        pos_next = {1'b0, best_reg};
                        st_next = S_FIX;
                        if (bent_reg.len != size_reg) begin
                            tgt_next = {1'b0, best_reg} + CntW'(1);
                            i_next = cnt_reg;
                            ph_next = '0;
                            st_next = S_SHUP;
                        end
                    end
                end else begin
                    glen_next = last_reg.free ? last_reg.len : '0;
                    gcap_next = cap_reg;
                    st_next = S_GROW;
                end
            end
            S_GROW: begin
                if (glen_reg >= size_reg) begin
                    need = (last_reg.free ? CntW'(0) : CntW'(1))
                         + ((glen_reg > size_reg) ? CntW'(1) : CntW'(0));
                    if ({1'b0, cnt_reg} + {1'b0, need} > (CntW+1)'(MaxRegions)) begin
                        sta_next = StFull; st_next = S_OUT;
                    end else begin
                        adr_next = last_reg.free ? last_reg.start : cap_reg[PoolAddrBits-1:0];
                        rsz_next = 1'b1;
                        cap_next = gcap_reg;
                        pos_next = last_reg.free ? cnt_reg - CntW'(1) : cnt_reg;
                        w0_next = '{start: adr_next, len: size_reg, free: 1'b0};
                        w1_next = '{start: adr_next + size_reg[PoolAddrBits-1:0],
                                    len: glen_reg - size_reg, free: 1'b1};
                        two_next = glen_reg > size_reg;
                        cnt_next = cnt_reg + need;
                        st_next = S_FIX;
                    end
                end else begin
                    g_start = 1'b1;
                    st_next = S_GWAIT;
                end
            end
            S_GWAIT: begin
                if (g_done) begin
                    if (g_result > PoolLimit) begin
                        sta_next = StOverflow; st_next = S_OUT;
                    end else begin
                        lsum = {1'b0, glen_reg} + {1'b0, g_result} - {1'b0, gcap_reg};
                        glen_next = lsum[LenW-1:0];
                        gcap_next = g_result;
                        st_next = S_GROW;
                    end
                end
            end
            S_SHUP: begin
                // move entries [tgt, cnt) up one; read k-1, write k
                if (i_reg == tgt_reg) begin
                    cnt_next = cnt_reg + CntW'(1);
                    st_next = S_FIX;
                end else if (ph_reg == 2'd0) begin
                    mreq.raddr = scan_idx[IdxW-1:0];
                    ph_next = 2'd1;
                end else begin
                    mreq.we = 1'b1;
                    mreq.waddr = i_reg[IdxW-1:0];
                    mreq.wdata = rdata;
                    i_next = scan_idx;
                    ph_next = 2'd0;
                end
            end
            S_FIX: begin
                mreq.we = 1'b1;
                if (ph_reg == 2'd0) begin
                    mreq.waddr = pos_reg[IdxW-1:0];
                    mreq.wdata = w0_reg;
                    ph_next = two_reg ? 2'd1 : 2'd0;
                    if (!two_reg) st_next = del_reg ? S_SHDN : S_OUT;
                end else begin
                    mreq.waddr = pos_reg[IdxW-1:0] + IdxW'(1);
                    mreq.wdata = w1_reg;
                    ph_next = 2'd0;
                    st_next = del_reg ? S_SHDN : S_OUT;
                end
                if (st_next == S_SHDN) begin
                    i_next = tgt_reg;
                end
            end
            S_SHDN: begin
                // remove del count entries at tgt: read k+n, write k
                if (i_reg + CntW'(cst_reg[1:0]) >= cnt_reg) begin
                    cnt_next = cnt_reg - CntW'(cst_reg[1:0]);
                    del_next = 1'b0;
                    st_next = S_OUT;
                end else if (ph_reg == 2'd0) begin
                    mreq.raddr = IdxW'(i_reg + CntW'(cst_reg[1:0]));
                    ph_next = 2'd1;
                end else begin
                    mreq.we = 1'b1;
                    mreq.waddr = i_reg[IdxW-1:0];
                    mreq.wdata = rdata;
                    i_next = i_reg + CntW'(1);
                    ph_next = 2'd0;
                end
            end
            S_FREE: begin
                mreq.raddr = i_reg[IdxW-1:0];
                if (rdata.start == fadr_reg) begin
                    if (rdata.free) begin
                        sta_next = StBadFree; st_next = S_OUT;
                    end else begin
                        bent_next = rdata;
                        best_next = scan_idx[IdxW-1:0];
                        st_next = S_RD;
                    end
                end else if (i_reg == cnt_reg) begin
                    sta_next = StBadFree; st_next = S_OUT;
                end else begin
                    prev_next = rdata;
                    i_next = i_reg + CntW'(1);
                end
            end
            S_RD: begin
                // rdata holds entry best+1 when it exists
                two_next = 1'b0;
                cst_next = '0;
                w0_next = bent_reg;
                w0_next.free = 1'b1;
                pos_next = {1'b0, best_reg};
                if (best_reg != '0 && prev_reg.free) begin
                    w0_next.start = prev_reg.start;
                    w0_next.len = prev_reg.len + bent_reg.len;
                    pos_next = {1'b0, best_reg} - CntW'(1);
                    cst_next = 3'd1;
                end
                if (i_reg != cnt_reg && rdata.free) begin
                    w0_next.len = w0_next.len + rdata.len;
                    cst_next = cst_next + 3'd1;
                end
                tgt_next = pos_next + CntW'(1);
                del_next = cst_next != '0;
                ph_next = '0;
                st_next = S_FIX;
            end
            S_OUT: begin
                if (!ov_reg || m_tready) begin
                    ov_next = 1'b1;
                    if (sta_next != StOk) begin
                        adr_next = '0;
                        rsz_next = 1'b0;
                    end
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_INIT; cnt_reg <= CntW'(1); cap_reg <= CapReset;
            grow_reg <= GrowReset; icap_reg <= CapReset; ov_reg <= 1'b0;
            ph_reg <= '0; del_reg <= 1'b0; cst_reg <= '0;
        end else begin
            st_reg <= st_next; cnt_reg <= cnt_next; cap_reg <= cap_next;
            grow_reg <= grow_next; icap_reg <= icap_next; ov_reg <= ov_next;
            ph_reg <= ph_next; del_reg <= del_next; cst_reg <= cst_next;
        end
        size_reg <= size_next; fadr_reg <= fadr_next;
        i_reg <= i_next; found_reg <= found_next; best_reg <= best_next;
        bent_reg <= bent_next; prev_reg <= prev_next; last_reg <= last_next;
        glen_reg <= glen_next; gcap_reg <= gcap_next; pos_reg <= pos_next;
        tgt_reg <= tgt_next; w0_reg <= w0_next; w1_reg <= w1_next;
        two_reg <= two_next; sta_reg <= sta_next; adr_reg <= adr_next;
        rsz_reg <= rsz_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 && cnt_reg <= CntW'(MaxRegions))
        else $error("region count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result lost under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cap_reg <= PoolLimit && cap_reg != '0)
        else $error("capacity out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && o_status != StOk |-> o_addr == '0 && !o_resized)
        else $error("error result carries payload");

endmodule

/* tb/bfra_checker.sv */
import bfra_pkg::*;
module bfra_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data,
    output int          errors,
    output int          outstanding
);

    typedef struct packed {
        logic [2:0]              status;
        logic [PoolAddrBits-1:0] addr;
        logic                    resized;
    } outcome_t;

    longint unsigned seg_start [MaxRegions];
    longint unsigned seg_len   [MaxRegions];
    bit              seg_free  [MaxRegions];
    int              seg_count;
    longint unsigned pool_cap;
    longint unsigned cap_reg;
    longint unsigned grow_reg;
    outcome_t        awaited[$];
    int              fail_count;

    function automatic void rebuild_pool();
        longint unsigned c;
        c = cap_reg;
        if (c < 1) c = 1;
        if (c > (64'd1 << PoolAddrBits)) c = 64'd1 << PoolAddrBits;
        for (int k = 0; k < MaxRegions; k++) begin
            seg_start[k] = 0;
            seg_len[k]   = 0;
            seg_free[k]  = 0;
        end
        seg_len[0]  = c;
        seg_free[0] = 1;
        seg_count   = 1;
        pool_cap    = c;
    endfunction

    function automatic void open_slot(int pos, longint unsigned st, longint unsigned ln, bit fr);
        for (int k = seg_count; k > pos; k--) begin
            seg_start[k] = seg_start[k-1];
            seg_len[k]   = seg_len[k-1];
            seg_free[k]  = seg_free[k-1];
        end
        seg_start[pos] = st;
        seg_len[pos]   = ln;
        seg_free[pos]  = fr;
        seg_count++;
    endfunction

    function automatic void close_slot(int pos);
        for (int k = pos; k + 1 < seg_count; k++) begin
            seg_start[k] = seg_start[k+1];
            seg_len[k]   = seg_len[k+1];
            seg_free[k]  = seg_free[k+1];
        end
        seg_count--;
        seg_start[seg_count] = 0;
        seg_len[seg_count]   = 0;
        seg_free[seg_count]  = 0;
    endfunction

    function automatic longint unsigned grown_capacity(longint unsigned c);
        longint unsigned g;
        longint unsigned n;
        g = (grow_reg < GrowMin) ? GrowMin : grow_reg;
        n = (c * g) >> 8;
        if (n <= c) n = c + 1;
        return n;
    endfunction

    function automatic outcome_t carve_region(longint unsigned size);
        outcome_t        o;
        int              best;
        bit              found;
        longint unsigned left;
        longint unsigned ln;
        longint unsigned st;
        longint unsigned c;
        longint unsigned n;
        int              last;
        int              need;
        int              idx;
        bit              last_free;
        o = '0;
        best = 0;
        found = 0;
        if (size == 0) begin
            o.status = StZero;
            return o;
        end
        for (int i = 0; i < seg_count; i++) begin
            if (seg_free[i] && seg_len[i] >= size && (!found || seg_len[i] < seg_len[best])) begin
                best = i;
                found = 1;
            end
        end
        if (found) begin
            left = seg_len[best] - size;
            if (left > 0 && seg_count + 1 > MaxRegions) begin
                o.status = StFull;
                return o;
            end
            seg_len[best]  = size;
            seg_free[best] = 0;
            if (left > 0) open_slot(best + 1, seg_start[best] + size, left, 1);
            o.addr = seg_start[best][PoolAddrBits-1:0];
            return o;
        end
        last      = seg_count - 1;
        last_free = seg_free[last];
        ln        = last_free ? seg_len[last] : 0;
        st        = last_free ? seg_start[last] : pool_cap;
        c         = pool_cap;
        while (ln < size) begin
            n = grown_capacity(c);
            if (n > (64'd1 << PoolAddrBits)) begin
                o.status = StOverflow;
                return o;
            end
            ln += n - c;
            c = n;
        end
        need = (last_free ? 0 : 1) + (ln > size ? 1 : 0);
        if (seg_count + need > MaxRegions) begin
            o.status = StFull;
            return o;
        end
        if (last_free) begin
            idx = last;
        end else begin
            idx = seg_count;
            open_slot(idx, st, 0, 0);
        end
        seg_len[idx]  = size;
        seg_free[idx] = 0;
        if (ln > size) open_slot(idx + 1, st + size, ln - size, 1);
        pool_cap  = c;
        o.addr    = st[PoolAddrBits-1:0];
        o.resized = 1'b1;
        return o;
    endfunction

    function automatic outcome_t release_region(longint unsigned address);
        outcome_t o;
        int       i;
        o = '0;
        i = 0;
        while (i < seg_count && seg_start[i] != address) i++;
        if (i >= seg_count || seg_free[i]) begin
            o.status = StBadFree;
            return o;
        end
        if (i > 0 && seg_free[i-1]) begin
            seg_len[i-1] += seg_len[i];
            close_slot(i);
            i--;
        end else begin
            seg_free[i] = 1;
        end
        if (i + 1 < seg_count && seg_free[i+1]) begin
            seg_len[i] += seg_len[i+1];
            close_slot(i + 1);
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        outcome_t want;
        outcome_t got;
        if (!aresetn) begin
            cap_reg  = CapReset;
            grow_reg = GrowReset;
            rebuild_pool();
            awaited.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CfgCapacity) begin
                    cap_reg = cfg_data;
                    rebuild_pool();
                end else begin
                    grow_reg = cfg_data[GrowW-1:0];
                end
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[2:0], m_tdata[26:3], m_tdata[27]};
                if (awaited.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result status=%0d addr=%0h resized=%0b",
                             $time, got.status, got.addr, got.resized);
                end else begin
                    want = awaited.pop_front();
                    if (got.status !== want.status) begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.addr !== want.addr) begin
                        fail_count++;
                        $display("%0t: alloc_address expected %0h actual %0h",
                                 $time, want.addr, got.addr);
                    end
                    if (got.resized !== want.resized) begin
                        fail_count++;
                        $display("%0t: resized expected %0b actual %0b",
                                 $time, want.resized, got.resized);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CmdAlloc) awaited.push_back(carve_region(s_tdata[24:0]));
                else awaited.push_back(release_region(s_tdata[48:25]));
            end
        end
        outstanding <= awaited.size();
        errors      <= fail_count;
    end

endmodule

/* tb/tb_top.sv */
import bfra_pkg::*;
module tb_top;

    localparam longint CycleLimit = 64'd60_000_000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata   = '0;  // req_size[24:0], req_address[48:25]
    logic        s_tuser   = 1'b0;  // command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;  // status[2:0], alloc_address[26:3], resized[27]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [24:0] cfg_data  = '0;
    int          errors;
    int          outstanding;
    bit          calm      = 1'b0;
    longint      cycles    = 0;
    logic        sent_cmds[$];
    logic [23:0] live[$];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    best_fit_region_allocator_top i_dut (.*);

    bfra_checker i_checker (.*);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(99) >= 15);
    end

    // track live allocations so frees mostly hit real regions
    always @(posedge aclk) begin
        logic c;
        if (aresetn && m_tvalid && m_tready && sent_cmds.size() > 0) begin
            c = sent_cmds.pop_front();
            if (c == CmdAlloc && m_tdata[2:0] == StOk) live.push_back(m_tdata[26:3]);
        end
        if (aresetn && s_tvalid && s_tready) sent_cmds.push_back(s_tuser);
    end

    task automatic send_request(logic cmd, logic [24:0] size, logic [23:0] address);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, address, size};
        do @(posedge aclk); while (!s_tready);
        if (!calm && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(logic index, logic [24:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (index == CfgCapacity) live.delete();
    endtask

    function automatic logic [24:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 25'($urandom_range(1, 256));
        if (r < 90) return 25'($urandom_range(1, 4096));
        if (r < 98) return 25'($urandom_range(1, 65536));
        return 25'($urandom);
    endfunction

    task automatic random_burst(int count);
        int r;
        int k;
        logic [23:0] a;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 5) begin
                send_request(CmdFree, 25'($urandom), 24'($urandom));
            end else if (r < 7) begin
                send_request(CmdAlloc, 25'd0, 24'($urandom));
            end else if (r < 10) begin
                send_request(CmdAlloc, 25'($urandom), 24'($urandom));
            end else if (live.size() > 0 && r < (live.size() > 40 ? 70 : 45)) begin
                k = $urandom_range(live.size() - 1);
                a = live[k];
                live.delete(k);
                send_request(CmdFree, 25'($urandom), a);
            end else begin
                send_request(CmdAlloc, pick_size(), 24'($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        send_request(CmdAlloc, 25'd0, 24'hFFFFFF);
        send_request(CmdAlloc, 25'd100, 24'd0);
        send_request(CmdAlloc, 25'd100, 24'd0);
        send_request(CmdFree, 25'h1FFFFFF, 24'd0);
        send_request(CmdFree, 25'd0, 24'd0);
        send_request(CmdAlloc, 25'd50, 24'd0);
        send_request(CmdFree, 25'd0, 24'd100);
        send_request(CmdFree, 25'd0, 24'd12345);
        send_request(CmdAlloc, 25'd3996, 24'd0);
        send_request(CmdAlloc, 25'd16777216, 24'd0);
        send_request(CmdAlloc, 25'd16777217, 24'd0);
        send_request(CmdAlloc, 25'h1FFFFFF, 24'd0);
        send_request(CmdFree, 25'd0, 24'hFFFFFF);
        send_request(CmdFree, 25'd0, 24'd50);
        send_request(CmdFree, 25'd0, 24'd0);
        settle();

        write_reg(CfgCapacity, 25'd4096);
        random_burst(330);
        settle();
        write_reg(CfgCapacity, 25'd0);
        write_reg(CfgGrowth, 11'd257);
        random_burst(300);
        settle();
        write_reg(CfgCapacity, 25'h1FFFFFF);
        write_reg(CfgGrowth, 25'h7FF);
        calm = 1'b1;
        random_burst(330);
        calm = 1'b0;
        settle();
        write_reg(CfgCapacity, 25'd16777216);
        write_reg(CfgGrowth, 25'd0);
        random_burst(330);
        settle();
        write_reg(CfgCapacity, 25'd300);
        write_reg(CfgGrowth, 25'd1024);
        random_burst(330);
        settle();
        write_reg(CfgCapacity, 25'd1);
        write_reg(CfgGrowth, 25'd384);
        random_burst(330);
        settle();

        repeat (300) @(posedge aclk);
        if (errors == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/bfra_pkg.sv
rtl/bfra_ram.sv
rtl/bfra_grow.sv
rtl/bfra_ctrl.sv
rtl/best_fit_region_allocator_top.sv
tb/bfra_checker.sv
tb/tb_top.sv
